@@ rtl/core/i2c_master_register_model_unit_assert.svh @@
// Assertion macros shared by the I2C master register block.
// Each macro checks a property on the rising clock edge, disabled while
// reset is high, and reports through $error.
`ifndef I2C_MASTER_REGISTER_MODEL_UNIT_ASSERT_SVH
`define I2C_MASTER_REGISTER_MODEL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm assertion failed");

`else

`define I2CM_ASSERT_SAME(label, clk, rst, ante, cons)
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/i2cm_pkg.sv @@
package i2cm_pkg;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register indexes that carry side effects or are read by other accesses.
  localparam logic [4:0] IX_IRQSTATUS_RAW = 5'd3;
  localparam logic [4:0] IX_IRQSTATUS     = 5'd4;
  localparam logic [4:0] IX_IRQENABLE_SET = 5'd5;
  localparam logic [4:0] IX_IRQENABLE_CLR = 5'd6;
  localparam logic [4:0] IX_CNT           = 5'd16;
  localparam logic [4:0] IX_DATA          = 5'd17;
  localparam logic [4:0] IX_CON           = 5'd18;
  localparam logic [4:0] IX_SA            = 5'd20;

  // Status and enable bit positions.
  localparam int BIT_RRDY  = 3;   // receive data ready
  localparam int BIT_XRDY  = 4;   // transmit data ready
  localparam int BIT_ARDY  = 8;   // access ready (stop)
  localparam int BIT_STP   = 2;   // raw status: stop done
  localparam int BIT_BB    = 12;  // raw status: bus busy after start
  localparam int CON_STT   = 0;   // start request
  localparam int CON_STP   = 1;   // stop request
  localparam int CON_TRX   = 9;   // transmit mode

  typedef struct packed {
    logic [31:0] read_value;
    logic        bus_start;
    logic [31:0] bus_address;
    logic        bus_send;
    logic [7:0]  bus_send_byte;
    logic        bus_fetch;
    logic        bus_stop;
    logic        irq_raise;
  } res_t;

endpackage

@@ rtl/core/i2c_master_register_model_unit.sv @@
// I2C master register block. Each input item is one register access: op
// selects read or write, reg_index picks one of REG_COUNT registers,
// write_value is the data of a write and bus_byte_in is the byte the bus
// returns if the access fetches one. Each item gives exactly one result item
// with the read data and the bus and interrupt strobes it caused.
// Both channels use valid and stall; an item moves on an edge with valid high
// and stall low. out_valid for a result rises when the result moves from
// stage one into the output register: the accepting edge starts the register
// memory read and latches the item in stage one, and the output register then takes it.
// The block takes one item per cycle as long as out_stall stays low; the
// single-ported read of the register memory sets that rate. When the
// receiver stalls, the waiting result holds still, one more item may enter
// behind it, and then in_stall rises until the output drains.
// Reset clears every register and both interrupt counters at once: the
// memory entries carry valid bits, so no clearing pass is needed and items
// are accepted in the first cycle after reset.
`include "i2c_master_register_model_unit_assert.svh"

module i2c_master_register_model_unit #(
  parameter int REG_COUNT = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [4:0]  reg_index,
  input  logic [31:0] write_value,
  input  logic [7:0]  bus_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_value,
  output logic        bus_start,
  output logic [31:0] bus_address,
  output logic        bus_send,
  output logic [7:0]  bus_send_byte,
  output logic        bus_fetch,
  output logic        bus_stop,
  output logic        irq_raise
);

  localparam int AW = $clog2(REG_COUNT);

  // Registers read by other accesses live in flip-flops; every other register
  // is only ever touched at its own index and lives in the memory.
  logic [31:0] st_raw, st_raw_next;
  logic [31:0] st_irq, st_irq_next;
  logic [31:0] en_set, en_set_next;
  logic [31:0] cnt, cnt_next;
  logic [31:0] data, data_next;
  logic [31:0] sa, sa_next;
  logic [31:0] rd_cnt, rd_cnt_next;
  logic [31:0] wr_cnt, wr_cnt_next;

  logic [REG_COUNT-1:0] vld;

  logic            in_accept;
  logic            adv_out;
  logic            in_range;
  logic            in_flop;
  logic [AW-1:0]   addr;
  logic            ram_we;
  logic            ram_re;
  logic [31:0]     ram_wdata;
  logic [31:0]     ram_rdata;

  i2cm_pkg::res_t  res0;
  logic            s1_valid;
  i2cm_pkg::res_t  s1_res;
  logic            s1_from_ram;
  logic            s1_hit;
  i2cm_pkg::res_t  s1_final;

  // The output register frees up when it is empty or being taken; the middle
  // stage accepts when it is empty or moving into the output register.
  assign adv_out   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !adv_out;
  assign in_accept = in_valid && !in_stall;

  assign in_range = int'(reg_index) < REG_COUNT;
  assign in_flop  = reg_index inside {i2cm_pkg::IX_IRQSTATUS_RAW, i2cm_pkg::IX_IRQSTATUS,
                                      i2cm_pkg::IX_IRQENABLE_SET, i2cm_pkg::IX_CNT,
                                      i2cm_pkg::IX_DATA, i2cm_pkg::IX_SA};
  assign addr     = AW'(reg_index);

  // A write to a memory register stores its value at accept. A read of one
  // starts the memory read; the data comes back with the item in stage one.
  // One item never both reads and writes, so no forwarding is needed.
  assign ram_re = in_accept && in_range && !in_flop && (op == i2cm_pkg::OP_READ);
  assign ram_we = in_accept && in_range && !in_flop && (op == i2cm_pkg::OP_WRITE);

  always_comb begin
    ram_wdata = write_value;
    if (reg_index == i2cm_pkg::IX_CON) begin
      if (write_value[i2cm_pkg::CON_STT]) begin
        ram_wdata[i2cm_pkg::CON_STT] = 1'b0;
      end else if (write_value[i2cm_pkg::CON_STP]) begin
        ram_wdata[i2cm_pkg::CON_STP] = 1'b0;
      end
    end
  end

  i2cm_ram #(
    .WIDTH (32),
    .DEPTH (REG_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // Side effects on the flip-flop registers and counters, and the strobes of
  // the result, all worked out from the current state at accept.
  always_comb begin
    st_raw_next = st_raw;
    st_irq_next = st_irq;
    en_set_next = en_set;
    cnt_next    = cnt;
    data_next   = data;
    sa_next     = sa;
    rd_cnt_next = rd_cnt;
    wr_cnt_next = wr_cnt;
    res0        = '0;

    if (in_range && op == i2cm_pkg::OP_READ) begin
      case (reg_index)
        i2cm_pkg::IX_IRQSTATUS_RAW: res0.read_value = st_raw;
        i2cm_pkg::IX_IRQSTATUS:     res0.read_value = st_irq;
        i2cm_pkg::IX_IRQENABLE_SET: res0.read_value = en_set;
        i2cm_pkg::IX_CNT:           res0.read_value = cnt;
        i2cm_pkg::IX_SA:            res0.read_value = sa;
        i2cm_pkg::IX_DATA: begin
          // Return the old byte and pull the next one from the bus.
          res0.read_value = data;
          data_next       = {24'd0, bus_byte_in};
          res0.bus_fetch  = 1'b1;
          if (en_set[i2cm_pkg::BIT_RRDY] && rd_cnt < cnt) begin
            st_irq_next[i2cm_pkg::BIT_RRDY] = 1'b1;
            res0.irq_raise = 1'b1;
            rd_cnt_next    = rd_cnt + 32'd1;
          end
        end
        default: res0.read_value = '0;
      endcase
    end else if (in_range) begin
      case (reg_index)
        i2cm_pkg::IX_IRQSTATUS_RAW: st_raw_next = write_value;
        i2cm_pkg::IX_IRQSTATUS:     st_irq_next = st_irq & ~write_value;
        i2cm_pkg::IX_IRQENABLE_SET: en_set_next = write_value;
        i2cm_pkg::IX_IRQENABLE_CLR: en_set_next = en_set & ~write_value;
        i2cm_pkg::IX_CNT:           cnt_next    = write_value;
        i2cm_pkg::IX_SA:            sa_next     = write_value;
        i2cm_pkg::IX_DATA: begin
          data_next          = write_value;
          res0.bus_send      = 1'b1;
          res0.bus_send_byte = write_value[7:0];
          if (en_set[i2cm_pkg::BIT_XRDY] && wr_cnt < cnt) begin
            st_irq_next[i2cm_pkg::BIT_XRDY] = 1'b1;
            res0.irq_raise = 1'b1;
            wr_cnt_next    = wr_cnt + 32'd1;
          end
        end
        i2cm_pkg::IX_CON: begin
          if (write_value[i2cm_pkg::CON_STT]) begin
            st_raw_next[i2cm_pkg::BIT_BB] = 1'b1;
            res0.bus_start = 1'b1;
            if (write_value[i2cm_pkg::CON_TRX]) begin
              // Transmit start: the write counter restarts.
              res0.bus_address = {sa[31:1], 1'b0};
              wr_cnt_next      = '0;
              if (en_set[i2cm_pkg::BIT_XRDY]) begin
                st_irq_next[i2cm_pkg::BIT_XRDY] = 1'b1;
                res0.irq_raise = 1'b1;
                wr_cnt_next    = 32'd1;
              end
            end else begin
              // Receive start: the first byte is fetched at once if enabled.
              res0.bus_address = {sa[31:1], 1'b1};
              rd_cnt_next      = '0;
              if (en_set[i2cm_pkg::BIT_RRDY]) begin
                st_irq_next[i2cm_pkg::BIT_RRDY] = 1'b1;
                data_next      = {24'd0, bus_byte_in};
                res0.bus_fetch = 1'b1;
                res0.irq_raise = 1'b1;
                rd_cnt_next    = 32'd1;
              end
            end
          end else if (write_value[i2cm_pkg::CON_STP]) begin
            st_raw_next[i2cm_pkg::BIT_STP] = 1'b1;
            res0.bus_stop = 1'b1;
            if (en_set[i2cm_pkg::BIT_ARDY]) begin
              st_irq_next[i2cm_pkg::BIT_ARDY] = 1'b1;
              res0.irq_raise = 1'b1;
            end
          end
        end
        default: begin
          // Plain registers are stored in the memory.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_raw <= '0;
      st_irq <= '0;
      en_set <= '0;
      cnt    <= '0;
      data   <= '0;
      sa     <= '0;
      rd_cnt <= '0;
      wr_cnt <= '0;
      vld    <= '0;
    end else if (in_accept) begin
      st_raw <= st_raw_next;
      st_irq <= st_irq_next;
      en_set <= en_set_next;
      cnt    <= cnt_next;
      data   <= data_next;
      sa     <= sa_next;
      rd_cnt <= rd_cnt_next;
      wr_cnt <= wr_cnt_next;
      if (ram_we) begin
        vld[addr] <= 1'b1;
      end
    end
  end

  // Stage one: the item waits here while its memory read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_res      <= res0;
      s1_from_ram <= ram_re;
      s1_hit      <= in_range && vld[addr];
    end
  end

  // A memory entry never written since reset reads as zero.
  always_comb begin
    s1_final = s1_res;
    if (s1_from_ram) begin
      s1_final.read_value = s1_hit ? ram_rdata : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      read_value    <= s1_final.read_value;
      bus_start     <= s1_final.bus_start;
      bus_address   <= s1_final.bus_address;
      bus_send      <= s1_final.bus_send;
      bus_send_byte <= s1_final.bus_send_byte;
      bus_fetch     <= s1_final.bus_fetch;
      bus_stop      <= s1_final.bus_stop;
      irq_raise     <= s1_final.irq_raise;
    end
  end

  `I2CM_ASSERT_SAME(a_start_stop_excl, clk, rst, out_valid, !(bus_start && bus_stop))
  `I2CM_ASSERT_SAME(a_send_no_read, clk, rst, out_valid && bus_send,
                    !bus_fetch && read_value == 32'd0)
  `I2CM_ASSERT_SAME(a_addr_only_start, clk, rst, out_valid && !bus_start,
                    bus_address == 32'd0)
  `I2CM_ASSERT_NEXT(a_rx_start_count, clk, rst,
                    in_accept && op == i2cm_pkg::OP_WRITE &&
                    reg_index == i2cm_pkg::IX_CON && in_range &&
                    write_value[i2cm_pkg::CON_STT] && !write_value[i2cm_pkg::CON_TRX] &&
                    en_set[i2cm_pkg::BIT_RRDY],
                    rd_cnt == 32'd1)

endmodule

@@ rtl/core/i2cm_ram.sv @@
module i2cm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sim/i2c_master_register_model_unit_tb.sv @@
`timescale 1ns / 100ps

module i2c_master_register_model_unit_tb;

  localparam int REG_COUNT = 31;
  // Cycles without any accepted item before the run is declared hung.
  localparam int HANG_LIMIT = 1000;
  // Length of the deliberate output hold that backs the block up.
  localparam int LONG_HOLD = 80;
  // Idle time at the end of the run, after every queued access has drained.
  localparam int DRAIN_CYCLES = 10;

  // One register access as the driver offers it.
  typedef struct packed {
    logic        op;
    logic [4:0]  idx;
    logic [31:0] wval;
    logic [7:0]  bus_byte;
  } access_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = 1'b0;
  logic [4:0]  reg_index = '0;
  logic [31:0] write_value = '0;
  logic [7:0]  bus_byte_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] read_value;
  logic        bus_start;
  logic [31:0] bus_address;
  logic        bus_send;
  logic [7:0]  bus_send_byte;
  logic        bus_fetch;
  logic        bus_stop;
  logic        irq_raise;

  i2c_master_register_model_unit #(.REG_COUNT(REG_COUNT)) uut (.*);

  // Shadow copy of the register file and the two interrupt counters. It is
  // advanced once per accepted access, in acceptance order.
  logic [31:0] regs [0:31];
  logic [31:0] rx_irq_cnt = '0;
  logic [31:0] tx_irq_cnt = '0;

  // Accesses waiting to be offered, and the bus effects predicted for the
  // accesses the block has already taken.
  access_t        queued_accesses[$];
  i2cm_pkg::res_t predicted_responses[$];
  int             accesses_queued = 0;

  access_t        offered;
  access_t        next_access;
  i2cm_pkg::res_t got, want;

  // Idle rates in percent, changed between phases by the stimulus process.
  int snd_idle_pct = 24;
  int rcv_idle_pct = 79;

  // The long hold is requested by toggling hold_req; the receiver answers by
  // copying it to hold_ack once the hold has run its full length.
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  int mismatches = 0;
  int results_seen = 0;
  int starts_seen = 0;
  int stops_seen = 0;
  int sends_seen = 0;
  int fetches_seen = 0;
  int irqs_seen = 0;
  int quiet_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Computes the bus effects of one access and updates the shadow state.
  // Reads of DATA pull in the bus byte, writes of DATA push out the low byte,
  // and both may raise an interrupt while their counter is below CNT. A CON
  // write with the start bit wins over the stop bit.
  function automatic i2cm_pkg::res_t apply_access(access_t a);
    i2cm_pkg::res_t r;
    logic [31:0]    con;
    r = '0;
    if (int'(a.idx) >= REG_COUNT) begin
      return r;
    end
    if (a.op == i2cm_pkg::OP_READ) begin
      r.read_value = regs[a.idx];
      if (a.idx == i2cm_pkg::IX_DATA) begin
        regs[i2cm_pkg::IX_DATA] = {24'd0, a.bus_byte};
        r.bus_fetch = 1'b1;
        if (regs[i2cm_pkg::IX_IRQENABLE_SET][i2cm_pkg::BIT_RRDY] &&
            rx_irq_cnt < regs[i2cm_pkg::IX_CNT]) begin
          regs[i2cm_pkg::IX_IRQSTATUS][i2cm_pkg::BIT_RRDY] = 1'b1;
          r.irq_raise = 1'b1;
          rx_irq_cnt = rx_irq_cnt + 32'd1;
        end
      end
      return r;
    end
    case (a.idx)
      i2cm_pkg::IX_IRQSTATUS: begin
        regs[i2cm_pkg::IX_IRQSTATUS] = regs[i2cm_pkg::IX_IRQSTATUS] & ~a.wval;
      end
      i2cm_pkg::IX_IRQENABLE_CLR: begin
        regs[i2cm_pkg::IX_IRQENABLE_CLR] = a.wval;
        regs[i2cm_pkg::IX_IRQENABLE_SET] = regs[i2cm_pkg::IX_IRQENABLE_SET] & ~a.wval;
      end
      i2cm_pkg::IX_DATA: begin
        regs[i2cm_pkg::IX_DATA] = a.wval;
        r.bus_send = 1'b1;
        r.bus_send_byte = a.wval[7:0];
        if (regs[i2cm_pkg::IX_IRQENABLE_SET][i2cm_pkg::BIT_XRDY] &&
            tx_irq_cnt < regs[i2cm_pkg::IX_CNT]) begin
          regs[i2cm_pkg::IX_IRQSTATUS][i2cm_pkg::BIT_XRDY] = 1'b1;
          r.irq_raise = 1'b1;
          tx_irq_cnt = tx_irq_cnt + 32'd1;
        end
      end
      i2cm_pkg::IX_CON: begin
        con = a.wval;
        if (con[i2cm_pkg::CON_STT]) begin
          con[i2cm_pkg::CON_STT] = 1'b0;
          regs[i2cm_pkg::IX_IRQSTATUS_RAW][i2cm_pkg::BIT_BB] = 1'b1;
          r.bus_start = 1'b1;
          if (con[i2cm_pkg::CON_TRX]) begin
            tx_irq_cnt = '0;
            r.bus_address = regs[i2cm_pkg::IX_SA] & ~32'd1;
            if (regs[i2cm_pkg::IX_IRQENABLE_SET][i2cm_pkg::BIT_XRDY]) begin
              regs[i2cm_pkg::IX_IRQSTATUS][i2cm_pkg::BIT_XRDY] = 1'b1;
              r.irq_raise = 1'b1;
              tx_irq_cnt = 32'd1;
            end
          end else begin
            rx_irq_cnt = '0;
            r.bus_address = regs[i2cm_pkg::IX_SA] | 32'd1;
            if (regs[i2cm_pkg::IX_IRQENABLE_SET][i2cm_pkg::BIT_RRDY]) begin
              regs[i2cm_pkg::IX_IRQSTATUS][i2cm_pkg::BIT_RRDY] = 1'b1;
              regs[i2cm_pkg::IX_DATA] = {24'd0, a.bus_byte};
              r.bus_fetch = 1'b1;
              r.irq_raise = 1'b1;
              rx_irq_cnt = 32'd1;
            end
          end
        end else if (con[i2cm_pkg::CON_STP]) begin
          con[i2cm_pkg::CON_STP] = 1'b0;
          regs[i2cm_pkg::IX_IRQSTATUS_RAW][i2cm_pkg::BIT_STP] = 1'b1;
          r.bus_stop = 1'b1;
          if (regs[i2cm_pkg::IX_IRQENABLE_SET][i2cm_pkg::BIT_ARDY]) begin
            regs[i2cm_pkg::IX_IRQSTATUS][i2cm_pkg::BIT_ARDY] = 1'b1;
            r.irq_raise = 1'b1;
          end
        end
        regs[i2cm_pkg::IX_CON] = con;
      end
      default: begin
        regs[a.idx] = a.wval;
      end
    endcase
    return r;
  endfunction

  // Driver. At each edge the offered access is predicted if the block took
  // it, and a new one is offered only when the slot is free, so a stalled
  // access never changes and valid never reacts to stall.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_responses.push_back(apply_access(offered));
      end
      if (!in_valid || !in_stall) begin
        if (queued_accesses.size() != 0 && int'($urandom_range(99)) >= snd_idle_pct) begin
          next_access = queued_accesses.pop_front();
          offered <= next_access;
          in_valid <= 1'b1;
          op <= next_access.op;
          reg_index <= next_access.idx;
          write_value <= next_access.wval;
          bus_byte_in <= next_access.bus_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall. A requested long hold takes priority over the random
  // stall pattern of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
      if (hold_left == 1) begin
        hold_ack <= hold_req;
      end
    end else if (hold_req != hold_ack) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
    end else begin
      out_stall <= (int'($urandom_range(99)) < rcv_idle_pct);
    end
  end

  // Monitor. Every accepted result is matched against the oldest prediction;
  // a result with nothing predicted counts as a mismatch too.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = {read_value, bus_start, bus_address, bus_send, bus_send_byte,
             bus_fetch, bus_stop, irq_raise};
      results_seen <= results_seen + 1;
      if (predicted_responses.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected result at %0t: rd=%h start=%b addr=%h", $realtime,
                   got.read_value, got.bus_start, got.bus_address);
        end
        mismatches <= mismatches + 1;
      end else begin
        want = predicted_responses.pop_front();
        starts_seen <= starts_seen + int'(want.bus_start);
        stops_seen <= stops_seen + int'(want.bus_stop);
        sends_seen <= sends_seen + int'(want.bus_send);
        fetches_seen <= fetches_seen + int'(want.bus_fetch);
        irqs_seen <= irqs_seen + int'(want.irq_raise);
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("Mismatch at %0t:", $realtime);
            $display("  expected rd=%h start=%b addr=%h send=%b byte=%h fetch=%b stop=%b irq=%b",
                     want.read_value, want.bus_start, want.bus_address, want.bus_send,
                     want.bus_send_byte, want.bus_fetch, want.bus_stop, want.irq_raise);
            $display("  actual   rd=%h start=%b addr=%h send=%b byte=%h fetch=%b stop=%b irq=%b",
                     got.read_value, got.bus_start, got.bus_address, got.bus_send,
                     got.bus_send_byte, got.bus_fetch, got.bus_stop, got.irq_raise);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // Watchdog. Any accepted item on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Timeout: no item accepted for %0d cycles", HANG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_access(input logic o, input logic [4:0] ix, input logic [31:0] wv,
                              input logic [7:0] b);
    access_t a;
    a.op = o;
    a.idx = ix;
    a.wval = wv;
    a.bus_byte = b;
    queued_accesses.push_back(a);
    accesses_queued++;
  endtask

  // A well-formed transfer: enable interrupts, set the count and slave
  // address, issue a start in one direction, move some data with a few
  // status reads and clears mixed in, then issue a stop.
  task automatic queue_transfer();
    logic        tx;
    logic [31:0] val;
    int          pick;
    tx = 1'($urandom_range(1));
    val = $urandom;
    val[i2cm_pkg::BIT_RRDY] = ($urandom_range(3) != 0);
    val[i2cm_pkg::BIT_XRDY] = ($urandom_range(3) != 0);
    val[i2cm_pkg::BIT_ARDY] = ($urandom_range(3) != 0);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_IRQENABLE_SET, val, 8'($urandom));
    if ($urandom_range(4) == 0) begin
      queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_IRQENABLE_CLR, $urandom, 8'($urandom));
    end
    val = ($urandom_range(4) == 0) ? $urandom : 32'($urandom_range(6));
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CNT, val, 8'($urandom));
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_SA, $urandom, 8'($urandom));
    val = $urandom;
    val[i2cm_pkg::CON_STT] = 1'b1;
    val[i2cm_pkg::CON_TRX] = tx;
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CON, val, 8'($urandom));
    repeat ($urandom_range(1, 8)) begin
      pick = int'($urandom_range(9));
      if (pick < 6) begin
        queue_access(tx ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ, i2cm_pkg::IX_DATA,
                     $urandom, 8'($urandom));
      end else if (pick == 6) begin
        queue_access(tx ? i2cm_pkg::OP_READ : i2cm_pkg::OP_WRITE, i2cm_pkg::IX_DATA,
                     $urandom, 8'($urandom));
      end else if (pick == 7) begin
        queue_access(i2cm_pkg::OP_READ, i2cm_pkg::IX_IRQSTATUS, $urandom, 8'($urandom));
      end else if (pick == 8) begin
        val = $urandom_range(1) ? 32'h0000_0118 : $urandom;
        queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_IRQSTATUS, val, 8'($urandom));
      end else begin
        queue_access(i2cm_pkg::OP_READ, 5'($urandom_range(31)), $urandom, 8'($urandom));
      end
    end
    val = $urandom;
    val[i2cm_pkg::CON_STT] = 1'b0;
    val[i2cm_pkg::CON_STP] = 1'b1;
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CON, val, 8'($urandom));
  endtask

  // Mostly transfers, with single random accesses in between that hit the
  // registers with side effects more often than plain ones.
  task automatic queue_random_traffic(input int count);
    int         target;
    logic [4:0] ix;
    target = accesses_queued + count;
    while (accesses_queued < target) begin
      if ($urandom_range(99) < 35) begin
        queue_transfer();
      end else begin
        case ($urandom_range(9))
          0: ix = i2cm_pkg::IX_CON;
          1: ix = i2cm_pkg::IX_DATA;
          2: ix = i2cm_pkg::IX_IRQSTATUS;
          3: ix = i2cm_pkg::IX_IRQENABLE_CLR;
          4: ix = i2cm_pkg::IX_IRQENABLE_SET;
          5: ix = i2cm_pkg::IX_CNT;
          6: ix = i2cm_pkg::IX_IRQSTATUS_RAW;
          default: ix = 5'($urandom_range(31));
        endcase
        queue_access(1'($urandom_range(1)), ix, $urandom, 8'($urandom));
      end
    end
  endtask

  // Returns once every queued access has been taken and answered.
  task automatic wait_drained();
    while (queued_accesses.size() != 0 || predicted_responses.size() != 0 || in_valid) begin
      @(negedge clk);
    end
  endtask

  // Stimulus. All queue and phase updates happen on the falling edge so
  // that the clocked processes always see a settled picture.
  initial begin
    for (int i = 0; i < 32; i++) begin
      regs[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: widest values, the top and the unknown index, both
    // start directions, start and stop together, stop alone, interrupt
    // counters running into CNT, the status clear and enable clear.
    queue_access(i2cm_pkg::OP_WRITE, 5'd30, 32'hFFFF_FFFF, 8'h00);
    queue_access(i2cm_pkg::OP_READ, 5'd30, 32'h0000_0000, 8'hFF);
    queue_access(i2cm_pkg::OP_WRITE, 5'd31, 32'hFFFF_FFFF, 8'hFF);
    queue_access(i2cm_pkg::OP_READ, 5'd31, 32'h0000_0000, 8'h00);
    queue_access(i2cm_pkg::OP_READ, 5'd0, 32'h0000_0000, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_IRQENABLE_SET, 32'hFFFF_FFFF, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CNT, 32'd2, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_SA, 32'hFFFF_FFFF, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CON, 32'h0000_0001, 8'hFF);
    queue_access(i2cm_pkg::OP_READ, i2cm_pkg::IX_DATA, 32'h0000_0000, 8'h00);
    queue_access(i2cm_pkg::OP_READ, i2cm_pkg::IX_DATA, 32'h0000_0000, 8'h5A);
    queue_access(i2cm_pkg::OP_READ, i2cm_pkg::IX_IRQSTATUS, 32'h0000_0000, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_IRQSTATUS, 32'hFFFF_FFFF, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CON, 32'h0000_0201, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_DATA, 32'hFFFF_FFFF, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_DATA, 32'h0000_0000, 8'hFF);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CON, 32'h0000_0003, 8'hA5);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CON, 32'h0000_0002, 8'h00);
    queue_access(i2cm_pkg::OP_READ, i2cm_pkg::IX_IRQSTATUS_RAW, 32'h0000_0000, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_IRQENABLE_CLR, 32'hFFFF_FFFF, 8'h00);
    queue_access(i2cm_pkg::OP_READ, i2cm_pkg::IX_IRQENABLE_SET, 32'h0000_0000, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CON, 32'h0000_0001, 8'h3C);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CON, 32'h0000_0000, 8'h00);
    queue_access(i2cm_pkg::OP_WRITE, i2cm_pkg::IX_CON, 32'hFFFF_FFFE, 8'h00);
    queue_access(i2cm_pkg::OP_READ, i2cm_pkg::IX_CON, 32'h0000_0000, 8'h00);

    // First random phase: the sender idles now and then, the receiver often.
    queue_random_traffic(400);
    wait_drained();

    // Back the block up: the receiver holds off while the sender keeps
    // offering, then the sender pauses until everything has drained.
    snd_idle_pct <= 0;
    hold_req <= ~hold_req;
    queue_random_traffic(40);
    wait_drained();

    // Second phase with the idle rates swapped.
    snd_idle_pct <= 79;
    rcv_idle_pct <= 24;
    queue_random_traffic(400);
    wait_drained();

    // Last phase runs at full rate on both sides.
    snd_idle_pct <= 0;
    rcv_idle_pct <= 0;
    queue_random_traffic(400);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d accesses: %0d starts, %0d stops, %0d sends,",
             results_seen, accesses_queued, starts_seen, stops_seen, sends_seen);
    $display("%0d fetches, %0d interrupts, over three idle mixes and one long output hold.",
             fetches_seen, irqs_seen);
    if (mismatches == 0 && predicted_responses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               predicted_responses.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
